// ----- design/pdaw_pkg.sv -----
// Shared types and constants for the PID controller with deadzones and
// integral clamp. No dependencies; every other design file uses this package.
`timescale 1ns / 1ps
`default_nettype none

package pdaw_pkg;

    localparam int GAIN_W     = 24;
    localparam int PERIOD_W   = 24;
    localparam int ILIM_W     = 47;
    localparam int OLIM_W     = 15;
    localparam int IDZ_W      = 16;
    localparam int ODZ_W      = 15;
    localparam int CFG_DATA_W = 47;
    localparam int CFG_IDX_W  = 3;
    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = 17;
    localparam int DIFF_W     = 18;
    localparam int INTEG_W    = 48;
    localparam int INT_FRAC   = 24;
    localparam int OUT_FRAC   = 16;
    localparam int MUL_W      = 25;
    localparam int PROD_W     = 50;
    localparam int ACC_W      = 52;
    localparam int SAT_W      = 32;
    localparam int DRIVE_W    = 16;

    localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ILIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OLIMIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_IDZ     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ODZ     = 3'd7;

    localparam logic [OLIM_W-1:0] OLIMIT_RESET = 15'h7FFF;

    typedef struct packed {
        logic [GAIN_W-1:0]   kp_gain;
        logic [GAIN_W-1:0]   ki_gain;
        logic [GAIN_W-1:0]   kd_gain;
        logic [PERIOD_W-1:0] sample_period;
        logic [ILIM_W-1:0]   integral_limit;
        logic [OLIM_W-1:0]   output_limit;
        logic [IDZ_W-1:0]    input_deadzone;
        logic [ODZ_W-1:0]    output_deadzone;
    } cfg_t;

    // register bank after reset: output_limit at full scale, all others zero
    localparam cfg_t CFG_RESET = cfg_t'({{(3*GAIN_W+PERIOD_W+ILIM_W){1'b0}},
                                        OLIMIT_RESET,
                                        {(IDZ_W+ODZ_W){1'b0}}});

    typedef enum logic [2:0] {
        MUL_EP,
        MUL_P,
        MUL_D,
        MUL_IH,
        MUL_IL
    } mul_sel_t;

    typedef enum logic [1:0] {
        ACC_NONE,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SHR
    } acc_op_t;

    typedef struct packed {
        logic     err_load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     int_update;
        acc_op_t  acc_op;
        logic     sat_load;
        logic     drive_load;
    } dp_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_EP,
        ST_INT,
        ST_MUL_P,
        ST_ACC_P,
        ST_MUL_D,
        ST_ACC_D,
        ST_MUL_IH,
        ST_ACC_IH,
        ST_MUL_IL,
        ST_ACC_IL,
        ST_SAT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- design/pdaw_regs.sv -----
// Configuration register bank for the PID controller.
// Depends on pdaw_pkg for register indexes, widths and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module pdaw_regs
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [pdaw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pdaw_pkg::CFG_DATA_W-1:0]   cfg_data,
    output pdaw_pkg::cfg_t                         cfg
);

    pdaw_pkg::cfg_t cfg_reg;
    pdaw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                pdaw_pkg::REG_KP:
                    cfg_next.kp_gain = cfg_data[pdaw_pkg::GAIN_W-1:0];
                pdaw_pkg::REG_KI:
                    cfg_next.ki_gain = cfg_data[pdaw_pkg::GAIN_W-1:0];
                pdaw_pkg::REG_KD:
                    cfg_next.kd_gain = cfg_data[pdaw_pkg::GAIN_W-1:0];
                pdaw_pkg::REG_PERIOD:
                    cfg_next.sample_period = cfg_data[pdaw_pkg::PERIOD_W-1:0];
                pdaw_pkg::REG_ILIMIT:
                    cfg_next.integral_limit = cfg_data[pdaw_pkg::ILIM_W-1:0];
                pdaw_pkg::REG_OLIMIT:
                    cfg_next.output_limit = cfg_data[pdaw_pkg::OLIM_W-1:0];
                pdaw_pkg::REG_IDZ:
                    cfg_next.input_deadzone = cfg_data[pdaw_pkg::IDZ_W-1:0];
                pdaw_pkg::REG_ODZ:
                    cfg_next.output_deadzone = cfg_data[pdaw_pkg::ODZ_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= pdaw_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/pdaw_ctrl.sv -----
// Sequencer for the PID controller: steps one word through the shared
// multiplier and accumulator and owns the handshake. Depends on pdaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdaw_ctrl
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    output pdaw_pkg::dp_cmd_t cmd
);

    pdaw_pkg::state_t state_reg;
    pdaw_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_free;

    // output slot can take a new word when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pdaw_pkg::ST_IDLE:   if (in_valid) state_next = pdaw_pkg::ST_MUL_EP;
            pdaw_pkg::ST_MUL_EP: state_next = pdaw_pkg::ST_INT;
            pdaw_pkg::ST_INT:    state_next = pdaw_pkg::ST_MUL_P;
            pdaw_pkg::ST_MUL_P:  state_next = pdaw_pkg::ST_ACC_P;
            pdaw_pkg::ST_ACC_P:  state_next = pdaw_pkg::ST_MUL_D;
            pdaw_pkg::ST_MUL_D:  state_next = pdaw_pkg::ST_ACC_D;
            pdaw_pkg::ST_ACC_D:  state_next = pdaw_pkg::ST_MUL_IH;
            pdaw_pkg::ST_MUL_IH: state_next = pdaw_pkg::ST_ACC_IH;
            pdaw_pkg::ST_ACC_IH: state_next = pdaw_pkg::ST_MUL_IL;
            pdaw_pkg::ST_MUL_IL: state_next = pdaw_pkg::ST_ACC_IL;
            pdaw_pkg::ST_ACC_IL: state_next = pdaw_pkg::ST_SAT;
            pdaw_pkg::ST_SAT:    state_next = pdaw_pkg::ST_OUT;
            pdaw_pkg::ST_OUT:    if (out_free) state_next = pdaw_pkg::ST_IDLE;
            default:             state_next = pdaw_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.mul_sel    = pdaw_pkg::MUL_EP;
        cmd.acc_op     = pdaw_pkg::ACC_NONE;
        in_stall       = 1'b1;
        case (state_reg)
            pdaw_pkg::ST_IDLE:
            begin
                in_stall     = 1'b0;
                cmd.err_load = in_valid;
            end
            pdaw_pkg::ST_MUL_EP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pdaw_pkg::MUL_EP;
            end
            pdaw_pkg::ST_INT:
                cmd.int_update = 1'b1;
            pdaw_pkg::ST_MUL_P:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pdaw_pkg::MUL_P;
            end
            pdaw_pkg::ST_ACC_P:
                cmd.acc_op = pdaw_pkg::ACC_LOAD;
            pdaw_pkg::ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pdaw_pkg::MUL_D;
            end
            pdaw_pkg::ST_ACC_D:
                cmd.acc_op = pdaw_pkg::ACC_ADD;
            pdaw_pkg::ST_MUL_IH:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pdaw_pkg::MUL_IH;
            end
            pdaw_pkg::ST_ACC_IH:
                cmd.acc_op = pdaw_pkg::ACC_ADD;
            pdaw_pkg::ST_MUL_IL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = pdaw_pkg::MUL_IL;
            end
            pdaw_pkg::ST_ACC_IL:
                cmd.acc_op = pdaw_pkg::ACC_ADD_SHR;
            pdaw_pkg::ST_SAT:
                cmd.sat_load = 1'b1;
            pdaw_pkg::ST_OUT:
                cmd.drive_load = out_free;
            default:
                cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.drive_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pdaw_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/pdaw_dp.sv -----
// Datapath for the PID controller: error and deadzone, integral with clamp,
// shared 25x25 multiplier, accumulator, saturation and output deadzone.
// Depends on pdaw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdaw_dp
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire pdaw_pkg::dp_cmd_t                   cmd,
    input  wire pdaw_pkg::cfg_t                      cfg,
    input  wire logic signed [pdaw_pkg::SAMPLE_W-1:0] measurement,
    input  wire logic signed [pdaw_pkg::SAMPLE_W-1:0] setpoint,
    output logic signed [pdaw_pkg::DRIVE_W-1:0]      drive_out
);

    // error and deadzone
    logic signed [pdaw_pkg::ERR_W-1:0]   err_raw;
    logic        [pdaw_pkg::ERR_W-1:0]   err_mag;
    logic signed [pdaw_pkg::ERR_W-1:0]   err_reg;
    logic signed [pdaw_pkg::ERR_W-1:0]   err_next;
    logic signed [pdaw_pkg::ERR_W-1:0]   prev_reg;
    logic signed [pdaw_pkg::DIFF_W-1:0]  diff_reg;

    // integral
    logic signed [pdaw_pkg::INTEG_W-1:0] integ_reg;
    logic signed [pdaw_pkg::INTEG_W-1:0] integ_next;
    logic signed [pdaw_pkg::PROD_W-1:0]  integ_sum;
    logic signed [pdaw_pkg::PROD_W-1:0]  ilim_pos;
    logic signed [pdaw_pkg::PROD_W-1:0]  ilim_neg;

    // multiplier
    logic signed [pdaw_pkg::MUL_W-1:0]   mul_a;
    logic signed [pdaw_pkg::MUL_W-1:0]   mul_b;
    logic signed [pdaw_pkg::PROD_W-1:0]  prod_reg;

    // accumulator and output
    logic signed [pdaw_pkg::ACC_W-1:0]   prod_ext;
    logic signed [pdaw_pkg::ACC_W-1:0]   prod_shr_ext;
    logic signed [pdaw_pkg::ACC_W-1:0]   acc_reg;
    logic signed [pdaw_pkg::ACC_W-1:0]   acc_next;
    logic signed [pdaw_pkg::ACC_W-1:0]   olim_pos;
    logic signed [pdaw_pkg::ACC_W-1:0]   olim_neg;
    logic signed [pdaw_pkg::ACC_W-1:0]   sat_full;
    logic signed [pdaw_pkg::SAT_W-1:0]   sat_reg;
    logic        [pdaw_pkg::SAT_W-1:0]   sat_mag;
    logic        [pdaw_pkg::ODZ_W-1:0]   drive_mag;
    logic signed [pdaw_pkg::DRIVE_W-1:0] drive_next;
    logic signed [pdaw_pkg::DRIVE_W-1:0] drive_reg;

    assign err_raw = {setpoint[pdaw_pkg::SAMPLE_W-1], setpoint}
                   - {measurement[pdaw_pkg::SAMPLE_W-1], measurement};
    assign err_mag = err_raw[pdaw_pkg::ERR_W-1] ? -err_raw : err_raw;
    assign err_next = (err_mag < {1'b0, cfg.input_deadzone}) ? '0 : err_raw;

    // integral + error*period, clamped to the symmetric limit
    assign integ_sum = {{2{integ_reg[pdaw_pkg::INTEG_W-1]}}, integ_reg} + prod_reg;
    assign ilim_pos  = {3'b000, cfg.integral_limit};
    assign ilim_neg  = -ilim_pos;

    always_comb
    begin
        if (integ_sum > ilim_pos)
            integ_next = ilim_pos[pdaw_pkg::INTEG_W-1:0];
        else if (integ_sum < ilim_neg)
            integ_next = ilim_neg[pdaw_pkg::INTEG_W-1:0];
        else
            integ_next = integ_sum[pdaw_pkg::INTEG_W-1:0];
    end

    always_comb
    begin
        case (cmd.mul_sel)
            pdaw_pkg::MUL_EP:
            begin
                mul_a = {{8{err_reg[pdaw_pkg::ERR_W-1]}}, err_reg};
                mul_b = {1'b0, cfg.sample_period};
            end
            pdaw_pkg::MUL_P:
            begin
                mul_a = {cfg.kp_gain[pdaw_pkg::GAIN_W-1], cfg.kp_gain};
                mul_b = {{8{err_reg[pdaw_pkg::ERR_W-1]}}, err_reg};
            end
            pdaw_pkg::MUL_D:
            begin
                mul_a = {cfg.kd_gain[pdaw_pkg::GAIN_W-1], cfg.kd_gain};
                mul_b = {{7{diff_reg[pdaw_pkg::DIFF_W-1]}}, diff_reg};
            end
            pdaw_pkg::MUL_IH:
            begin
                mul_a = {cfg.ki_gain[pdaw_pkg::GAIN_W-1], cfg.ki_gain};
                mul_b = {integ_reg[pdaw_pkg::INTEG_W-1],
                         integ_reg[pdaw_pkg::INTEG_W-1:pdaw_pkg::INT_FRAC]};
            end
            pdaw_pkg::MUL_IL:
            begin
                mul_a = {cfg.ki_gain[pdaw_pkg::GAIN_W-1], cfg.ki_gain};
                mul_b = {1'b0, integ_reg[pdaw_pkg::INT_FRAC-1:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // low integral part: arithmetic shift floors the partial product
    assign prod_ext     = {{2{prod_reg[pdaw_pkg::PROD_W-1]}}, prod_reg};
    assign prod_shr_ext = {{26{prod_reg[pdaw_pkg::PROD_W-1]}},
                           prod_reg[pdaw_pkg::PROD_W-1:pdaw_pkg::INT_FRAC]};

    always_comb
    begin
        case (cmd.acc_op)
            pdaw_pkg::ACC_NONE:    acc_next = acc_reg;
            pdaw_pkg::ACC_LOAD:    acc_next = prod_ext;
            pdaw_pkg::ACC_ADD:     acc_next = acc_reg + prod_ext;
            pdaw_pkg::ACC_ADD_SHR: acc_next = acc_reg + prod_shr_ext;
            default:               acc_next = acc_reg;
        endcase
    end

    assign olim_pos = {21'd0, cfg.output_limit, 16'd0};
    assign olim_neg = -olim_pos;

    always_comb
    begin
        if (acc_reg > olim_pos)
            sat_full = olim_pos;
        else if (acc_reg < olim_neg)
            sat_full = olim_neg;
        else
            sat_full = acc_reg;
    end

    // truncate toward zero, then drop magnitudes inside the output deadzone
    assign sat_mag   = sat_reg[pdaw_pkg::SAT_W-1] ? -sat_reg : sat_reg;
    assign drive_mag = sat_mag[pdaw_pkg::SAT_W-2:pdaw_pkg::OUT_FRAC];

    always_comb
    begin
        if (drive_mag < cfg.output_deadzone)
            drive_next = '0;
        else if (sat_reg[pdaw_pkg::SAT_W-1])
            drive_next = -$signed({1'b0, drive_mag});
        else
            drive_next = {1'b0, drive_mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else if (cmd.int_update)
        begin
            integ_reg <= integ_next;
            prev_reg  <= err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.err_load)
            err_reg <= err_next;
        if (cmd.int_update)
            diff_reg <= {err_reg[pdaw_pkg::ERR_W-1], err_reg}
                      - {prev_reg[pdaw_pkg::ERR_W-1], prev_reg};
        if (cmd.mul_en)
            prod_reg <= mul_a * mul_b;
        acc_reg <= acc_next;
        if (cmd.sat_load)
            sat_reg <= sat_full[pdaw_pkg::SAT_W-1:0];
        if (cmd.drive_load)
            drive_reg <= drive_next;
    end

    assign drive_out = drive_reg;

endmodule

`default_nettype wire

// ----- design/pid_deadzone_antiwindup.sv -----
// PID controller with input deadzone, clamped integral and output saturation.
// Each accepted input word passes five times through the shared 25x25 multiplier
// (error*period, then P, D and high and low integral terms, the last four each
// followed by an accumulate step). A new word is taken only back in the idle state;
// a stalled output word holds the next result until it drains.
// Reset: asynchronous active low; clears integral and previous error, output_limit 32767.
`timescale 1ns / 1ps
`default_nettype none

module pid_deadzone_antiwindup
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [pdaw_pkg::SAMPLE_W-1:0] measurement,
    input  wire logic signed [pdaw_pkg::SAMPLE_W-1:0] setpoint,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [pdaw_pkg::DRIVE_W-1:0]       drive_out,
    input  wire logic                                 cfg_we,
    input  wire logic [pdaw_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [pdaw_pkg::CFG_DATA_W-1:0]      cfg_data
);

    pdaw_pkg::cfg_t    cfg;
    pdaw_pkg::dp_cmd_t cmd;

    pdaw_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pdaw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    pdaw_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg         (cfg),
        .measurement (measurement),
        .setpoint    (setpoint),
        .drive_out   (drive_out)
    );

endmodule

`default_nettype wire
